// ===== hdl/sfce_pkg.sv =====
// ----------------------------------------------------------------------------
// sfce_pkg
// Shared constants and types of the serial flash command engine.
// ----------------------------------------------------------------------------
package sfce_pkg;

  localparam int unsigned STORE_ADDR_BITS = 20;
  localparam int unsigned STORE_DEPTH     = 1 << STORE_ADDR_BITS;
  localparam int unsigned FIFO_DEPTH      = 4;
  localparam int unsigned FIFO_PTR_W      = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CMD_IDENT   = 8'h08;
  localparam logic [7:0] CMD_NOP     = 8'h00;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_WRITE   = 8'h0A;
  localparam logic [7:0] CMD_PROG    = 8'h02;
  localparam logic [7:0] CMD_WRDI    = 8'h04;
  localparam logic [7:0] CMD_RDSR    = 8'h05;
  localparam logic [7:0] CMD_WREN    = 8'h06;
  localparam logic [7:0] IDENT_REPLY = 8'hAA;
  localparam logic [7:0] WEL_MASK    = 8'h02;
  localparam logic [7:0] ERASED_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    OP_CONST = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_PROG  = 2'd3
  } op_kind_e;

  typedef struct packed {
    op_kind_e                   kind;
    logic [STORE_ADDR_BITS-1:0] addr;
    logic [7:0]                 data;
  } sfce_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== hdl/sfce_ram.sv =====
// ----------------------------------------------------------------------------
// sfce_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sfce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sfce_front.sv =====
// ----------------------------------------------------------------------------
// sfce_front
// Command decoder: tracks mode, address and status, and turns each
// incoming word into one store operation for the back end.
// ----------------------------------------------------------------------------
module sfce_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    op_i,
  input  logic [7:0]              data_in_i,
  input  logic                    clr_done_i,
  input  sfce_pkg::fifo_status_t  fifo_status_i,
  output logic                    push_o,
  output sfce_pkg::sfce_op_t      push_op_o
);
  import sfce_pkg::*;

  typedef enum logic [2:0] {
    MODE_WAIT   = 3'd0,
    MODE_ADDR   = 3'd1,
    MODE_READ   = 3'd2,
    MODE_WRITE  = 3'd3,
    MODE_PROG   = 3'd4,
    MODE_STATUS = 3'd5
  } mode_e;

  mode_e       mode_q, mode_d;
  mode_e       after_q, after_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [1:0]  cnt_eff;
  logic [23:0] addr_q, addr_d;
  logic [7:0]  status_q, status_d;
  sfce_op_t    op;

  assign in_ready_o = clr_done_i && !fifo_status_i.full;
  assign push_o     = in_valid_i && in_ready_o;
  assign push_op_o  = op;
  assign cnt_eff    = (cnt_q == 2'd3) ? 2'd0 : cnt_q;

  always_comb begin
    mode_d   = mode_q;
    after_d  = after_q;
    cnt_d    = cnt_q;
    addr_d   = addr_q;
    status_d = status_q;
    op.kind  = OP_CONST;
    op.addr  = addr_q[STORE_ADDR_BITS-1:0];
    op.data  = 8'h00;
    if (op_i) begin
      mode_d = MODE_WAIT;
    end else begin
      case (mode_q)
        MODE_ADDR: begin
          case (cnt_eff)
            2'd0:    addr_d[23:16] = data_in_i;
            2'd1:    addr_d[15:8]  = data_in_i;
            default: addr_d[7:0]   = data_in_i;
          endcase
          if (cnt_eff == 2'd2) begin
            cnt_d  = 2'd0;
            mode_d = after_q;
          end else begin
            cnt_d = cnt_eff + 2'd1;
          end
        end
        MODE_READ: begin
          op.kind = OP_READ;
          addr_d  = addr_q + 24'd1;
        end
        MODE_WRITE: begin
          op.kind = OP_WRITE;
          op.data = data_in_i;
          addr_d  = addr_q + 24'd1;
        end
        MODE_PROG: begin
          op.kind = OP_PROG;
          op.data = data_in_i;
          addr_d  = addr_q + 24'd1;
        end
        MODE_STATUS: begin
          op.data = status_q;
        end
        default: begin
          case (data_in_i)
            CMD_IDENT: op.data = IDENT_REPLY;
            CMD_READ: begin
              mode_d  = MODE_ADDR;
              after_d = MODE_READ;
            end
            CMD_WRITE: begin
              mode_d  = MODE_ADDR;
              after_d = MODE_WRITE;
            end
            CMD_PROG: begin
              mode_d  = MODE_ADDR;
              after_d = MODE_PROG;
            end
            CMD_WRDI: begin
              status_d = status_q & ~WEL_MASK;
              mode_d   = MODE_WAIT;
            end
            CMD_RDSR: mode_d = MODE_STATUS;
            CMD_WREN: begin
              status_d = status_q | WEL_MASK;
              mode_d   = MODE_WAIT;
            end
            default: ;
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_WAIT;
      after_q  <= MODE_WAIT;
      cnt_q    <= 2'd0;
      addr_q   <= 24'd0;
      status_q <= 8'h00;
    end else if (push_o) begin
      mode_q   <= mode_d;
      after_q  <= after_d;
      cnt_q    <= cnt_d;
      addr_q   <= addr_d;
      status_q <= status_d;
    end
  end

endmodule

// ===== hdl/sfce_fifo.sv =====
// ----------------------------------------------------------------------------
// sfce_fifo
// Short operation queue between the decoder and the store engine.
// ----------------------------------------------------------------------------
module sfce_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sfce_pkg::sfce_op_t     push_op_i,
  input  logic                   pop_i,
  output sfce_pkg::sfce_op_t     head_o,
  output sfce_pkg::fifo_status_t status_o
);
  import sfce_pkg::*;

  sfce_op_t              entry_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, rptr_q;
  logic [FIFO_PTR_W:0]   cnt_q;

  assign head_o         = entry_q[rptr_q];
  assign status_o.full  = (cnt_q == FIFO_DEPTH[FIFO_PTR_W:0]);
  assign status_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/sfce_back.sv =====
// ----------------------------------------------------------------------------
// sfce_back
// Store engine: erases the store after reset, then carries out queued
// operations in order and drives the output word register.
// ----------------------------------------------------------------------------
module sfce_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sfce_pkg::sfce_op_t              head_i,
  input  sfce_pkg::fifo_status_t          fifo_status_i,
  output logic                            pop_o,
  output logic                            clr_done_o,
  output logic                            ram_we_o,
  output logic [sfce_pkg::STORE_ADDR_BITS-1:0] ram_waddr_o,
  output logic [7:0]                      ram_wdata_o,
  output logic                            ram_re_o,
  output logic [sfce_pkg::STORE_ADDR_BITS-1:0] ram_raddr_o,
  input  logic [7:0]                      ram_rdata_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      data_out_o
);
  import sfce_pkg::*;

  typedef enum logic [1:0] {
    ST_CLEAR   = 2'd0,
    ST_IDLE    = 2'd1,
    ST_RD_WAIT = 2'd2,
    ST_PG_WAIT = 2'd3
  } state_e;

  state_e                     state_q;
  logic [STORE_ADDR_BITS-1:0] clr_q;
  logic [STORE_ADDR_BITS-1:0] pend_addr_q;
  logic [7:0]                 pend_data_q;
  logic                       out_valid_q;
  logic [7:0]                 out_data_q;
  logic [7:0]                 out_data_d;
  logic                       out_load;
  logic                       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = (state_q == ST_IDLE) && !fifo_status_i.empty && out_free;
  assign clr_done_o  = (state_q != ST_CLEAR);
  assign ram_re_o    = pop_o && ((head_i.kind == OP_READ) || (head_i.kind == OP_PROG));
  assign ram_raddr_o = head_i.addr;
  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_data_q;

  always_comb begin
    ram_we_o    = 1'b0;
    ram_waddr_o = head_i.addr;
    ram_wdata_o = head_i.data;
    out_load    = 1'b0;
    out_data_d  = 8'h00;
    case (state_q)
      ST_CLEAR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = clr_q;
        ram_wdata_o = ERASED_BYTE;
      end
      ST_IDLE: begin
        ram_we_o = pop_o && (head_i.kind == OP_WRITE);
        out_load = pop_o && ((head_i.kind == OP_WRITE) || (head_i.kind == OP_CONST));
        if (head_i.kind == OP_CONST) begin
          out_data_d = head_i.data;
        end
      end
      ST_RD_WAIT: begin
        out_load   = out_free;
        out_data_d = ram_rdata_i;
      end
      ST_PG_WAIT: begin
        ram_we_o    = out_free;
        ram_waddr_o = pend_addr_q;
        ram_wdata_o = ram_rdata_i & pend_data_q;
        out_load    = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= 8'h00;
      pend_addr_q <= '0;
      pend_data_q <= 8'h00;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_data_q  <= out_data_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop_o) begin
            pend_addr_q <= head_i.addr;
            pend_data_q <= head_i.data;
            case (head_i.kind)
              OP_READ: state_q <= ST_RD_WAIT;
              OP_PROG: state_q <= ST_PG_WAIT;
              default: ;
            endcase
          end
        end
        ST_RD_WAIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== hdl/serial_flash_command_engine.sv =====
// ----------------------------------------------------------------------------
// serial_flash_command_engine
// Serial flash command engine: decodes host words into store operations
// and returns one reply word per input word.
//
//   channel | signals                           | direction
//   input   | in_valid_i in_ready_o op_i data_in_i | host -> engine
//   output  | out_valid_o out_ready_i data_out_o   | engine -> host
//
// Write and constant replies are loaded as their operation is popped; read
// and program replies pass the registered read port and a wait state first.
// The decoder takes a word every cycle while the four-entry queue has room.
// After reset the store is erased, one byte a cycle, over all
// 2^STORE_ADDR_BITS (1048576) addresses; in_ready_o stays low until then.
// A stalled output holds the engine; the queue keeps the decoder moving.
// ----------------------------------------------------------------------------
module serial_flash_command_engine (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       op_i,
  input  logic [7:0] data_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_out_o
);
  import sfce_pkg::*;

  logic                       push;
  sfce_op_t                   push_op;
  logic                       pop;
  sfce_op_t                   head;
  fifo_status_t               fifo_status;
  logic                       clr_done;
  logic                       ram_we;
  logic [STORE_ADDR_BITS-1:0] ram_waddr;
  logic [7:0]                 ram_wdata;
  logic                       ram_re;
  logic [STORE_ADDR_BITS-1:0] ram_raddr;
  logic [7:0]                 ram_rdata;

  sfce_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .data_in_i     (data_in_i),
    .clr_done_i    (clr_done),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .push_op_o     (push_op)
  );

  sfce_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .head_o    (head),
    .status_o  (fifo_status)
  );

  sfce_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .clr_done_o    (clr_done),
    .ram_we_o      (ram_we),
    .ram_waddr_o   (ram_waddr),
    .ram_wdata_o   (ram_wdata),
    .ram_re_o      (ram_re),
    .ram_raddr_o   (ram_raddr),
    .ram_rdata_i   (ram_rdata),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_out_o    (data_out_o)
  );

  sfce_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
